[hdl/grouped_sorted_insert_queue_assert.svh]
// Assertion macros for the grouped sorted insert queue
`ifndef GROUPED_SORTED_INSERT_QUEUE_ASSERT_SVH
`define GROUPED_SORTED_INSERT_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
// Check that a condition implies a consequence in the same cycle
`define GSIQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gsiq assertion failed");
// Check that a condition implies a consequence in the following cycle
`define GSIQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gsiq assertion failed");
`else
`define GSIQ_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define GSIQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/gsiq_pkg.sv]
// Types and constants shared by the grouped sorted insert queue
`timescale 1ns / 1ps
package gsiq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int POS_BITS_DEF = 32;
    localparam int ID_BITS_DEF  = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_POPPED   = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic        op;
        logic [31:0] position;
        logic [31:0] node_id;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] out_position;
        logic [31:0] out_node_id;
        logic        last;
    } out_beat_t;

    // Control broadcast from the controller to every cell
    typedef struct packed {
        logic ins;
        logic shift;
        logic largest_first;
    } cell_ctrl_t;

endpackage

[hdl/gsiq_cell.sv]
// One storage cell of the sorted chain: holds one entry, inserts or shifts
`timescale 1ns / 1ps
module gsiq_cell #(
    parameter int POS_BITS = gsiq_pkg::POS_BITS_DEF,
    parameter int ID_BITS  = gsiq_pkg::ID_BITS_DEF
) (
    input  logic                clk,
    input  gsiq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                found_in,
    output logic                found_out,
    input  logic [POS_BITS-1:0] new_pos,
    input  logic [ID_BITS-1:0]  new_id,
    input  logic [POS_BITS-1:0] prev_pos,
    input  logic [ID_BITS-1:0]  prev_id,
    input  logic [POS_BITS-1:0] next_pos,
    input  logic [ID_BITS-1:0]  next_id,
    output logic [POS_BITS-1:0] pos,
    output logic [ID_BITS-1:0]  id
);
    import gsiq_pkg::*;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic                below;
    logic                take;

    // Rank the held entry against the incoming one
    assign below = occupied &&
                   (ctrl.largest_first ? (pos_reg < new_pos) : (pos_reg > new_pos));

    // Claim the slot if no earlier cell did and this is the first lower or free one
    assign take      = !found_in && (below || !occupied);
    assign found_out = found_in || take;

    // Load the new entry, move down from the left, or move up from the right
    always_comb
    begin
        pos_next = pos_reg;
        id_next  = id_reg;
        priority if (ctrl.ins && take)
        begin
            pos_next = new_pos;
            id_next  = new_id;
        end
        else if (ctrl.ins && found_in)
        begin
            pos_next = prev_pos;
            id_next  = prev_id;
        end
        else if (ctrl.shift)
        begin
            pos_next = next_pos;
            id_next  = next_id;
        end
        else
        begin
            // hold the entry
            pos_next = pos_reg;
            id_next  = id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        id_reg  <= id_next;
    end

    assign pos = pos_reg;
    assign id  = id_reg;

endmodule

[hdl/grouped_sorted_insert_queue.sv]
// Top level of the grouped sorted insert queue: controller, cell chain, output register
//
// Priority queue of up to CAPACITY (position, id) entries held in a chain of
// cells, kept sorted by position with equal positions in arrival order. An
// insert (op 0) has every cell compare its entry with the new one at once;
// the first cell that ranks strictly lower (or the first free one) takes it
// and all later cells move one place down. A pop (op 1) of a head group of
// n entries first accepts the request, then gives one result per cycle while
// the output is not stalled, as the chain shifts one place toward the head; no input is
// taken meanwhile. A pop on an empty queue or an insert on a full one returns
// a single status beat. largest_first (reset 1) picks whether the largest or
// the smallest position leads; write it only while the block is idle. Stored
// entries are not re-sorted when it changes. No clearing pass follows reset.
`timescale 1ns / 1ps
module grouped_sorted_insert_queue #(
    parameter int CAPACITY = gsiq_pkg::CAPACITY_DEF,
    parameter int POS_BITS = gsiq_pkg::POS_BITS_DEF,
    parameter int ID_BITS  = gsiq_pkg::ID_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gsiq_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output gsiq_pkg::out_beat_t out_data,
    input  logic               cfg_write,
    input  logic               cfg_data
);
    import gsiq_pkg::*;

    `include "grouped_sorted_insert_queue_assert.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               largest_first_reg;
    logic               out_valid_reg, out_valid_next;
    out_beat_t          out_data_reg, out_data_next;

    logic [POS_BITS-1:0] pos_q [CAPACITY+2];
    logic [ID_BITS-1:0]  id_q  [CAPACITY+2];
    logic [CAPACITY:0]   found;
    logic [CAPACITY-1:0] occupied;

    logic                out_free;
    logic                in_accept;
    logic                is_full;
    logic                ins_go;
    logic                pop_emit;
    logic                pop_last;
    logic [POS_BITS-1:0] new_pos;
    logic [ID_BITS-1:0]  new_id;
    cell_ctrl_t          ctrl;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign ins_go    = in_accept && (in_data.op == OP_INSERT) && !is_full;
    assign pop_emit  = (state_reg == ST_POP) && out_free;
    assign pop_last  = (count_reg == CNT_W'(1)) || (pos_q[2] != pos_q[1]);

    assign new_pos = POS_BITS'(in_data.position);
    assign new_id  = ID_BITS'(in_data.node_id);

    assign ctrl.ins           = ins_go;
    assign ctrl.shift         = pop_emit;
    assign ctrl.largest_first = largest_first_reg;

    // Tie off the chain ends
    assign pos_q[0]          = '0;
    assign id_q[0]           = '0;
    assign pos_q[CAPACITY+1] = '0;
    assign id_q[CAPACITY+1]  = '0;
    assign found[0]          = 1'b0;

    // Build the cell chain
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        assign occupied[g] = (CNT_W'(g) < count_reg);

        gsiq_cell #(
            .POS_BITS (POS_BITS),
            .ID_BITS  (ID_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occupied[g]),
            .found_in  (found[g]),
            .found_out (found[g+1]),
            .new_pos   (new_pos),
            .new_id    (new_id),
            .prev_pos  (pos_q[g]),
            .prev_id   (id_q[g]),
            .next_pos  (pos_q[g+2]),
            .next_id   (id_q[g+2]),
            .pos       (pos_q[g+1]),
            .id        (id_q[g+1])
        );
    end

    // Sequence control, count and output beat
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (in_data.op == OP_INSERT)
                    begin
                        out_valid_next             = 1'b1;
                        out_data_next.status       = is_full ? STATUS_FULL : STATUS_INSERTED;
                        out_data_next.out_position = in_data.position;
                        out_data_next.out_node_id  = in_data.node_id;
                        out_data_next.last         = 1'b1;
                        if (!is_full)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next             = 1'b1;
                        out_data_next.status       = STATUS_EMPTY;
                        out_data_next.out_position = '0;
                        out_data_next.out_node_id  = '0;
                        out_data_next.last         = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                if (pop_emit)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = STATUS_POPPED;
                    out_data_next.out_position = 32'(pos_q[1]);
                    out_data_next.out_node_id  = 32'(id_q[1]);
                    out_data_next.last         = pop_last;
                    count_next                 = count_reg - CNT_W'(1);
                    if (pop_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
            largest_first_reg <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                largest_first_reg <= cfg_data;
            end
        end
    end

    // Hold the payload register without reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `GSIQ_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `GSIQ_ASSERT_SAME(a_pop_not_empty, clk, rst_n, state_reg == ST_POP, count_reg != '0)
    `GSIQ_ASSERT_SAME(a_insert_finds_slot, clk, rst_n, ctrl.ins, found[CAPACITY])
    `GSIQ_ASSERT_NEXT(a_insert_counts, clk, rst_n, ins_go, count_reg == $past(count_reg) + 1'b1)
    `GSIQ_ASSERT_NEXT(a_last_ends_pop, clk, rst_n, pop_emit && pop_last, state_reg == ST_IDLE)

endmodule
